@@ rtl/core/rsp_pkg.sv @@
// shared types, constants and field arithmetic for the reed-solomon parity encoder
package rsp_pkg;

    localparam int MAX_PARITY_DEF = 30;
    localparam int RESET_PARITY   = 7;
    localparam int CFG_W          = 5;
    localparam int BYTE_W         = 8;
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [8:0] GF_TOP  = 9'h100;

    typedef logic [BYTE_W-1:0] t_byte;

    // per-cycle commands shared by every cell of the chain
    typedef struct packed {
        logic init;     // reload generator seed and clear the remainder
        logic build;    // one generator multiply by (x + root)
        logic shift;    // one message byte enters the remainder
        logic last;     // that byte closes the block
    } t_cell_ctl;

    function automatic t_byte gf_xtime(input t_byte a);
        logic [8:0] s;
        s = {a, 1'b0};
        if ((s & GF_TOP) != 9'd0) begin
            s = s ^ GF_POLY;
        end
        return s[BYTE_W-1:0];
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte p;
        acc = '0;
        p   = a;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                acc = acc ^ p;
            end
            p = gf_xtime(p);
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/rsp_if.sv @@
// item channels of the reed-solomon parity encoder
interface rsp_in_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsp_out_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           parity_byte;
    logic                 parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

@@ rtl/core/rsp_cell.sv @@
// one cell of the chain: a generator coefficient, a remainder byte and a parity capture byte
module rsp_cell (
    input  logic               i_clk,
    input  rsp_pkg::t_cell_ctl i_ctl,
    input  logic               i_seed,
    input  rsp_pkg::t_byte     i_root,
    input  rsp_pkg::t_byte     i_fb,
    input  rsp_pkg::t_byte     i_prev_g,
    input  rsp_pkg::t_byte     i_prev_c,
    output rsp_pkg::t_byte     o_g,
    output rsp_pkg::t_byte     o_c,
    output rsp_pkg::t_byte     o_par
);

    rsp_pkg::t_byte r_g;
    rsp_pkg::t_byte r_c;
    rsp_pkg::t_byte r_par;
    rsp_pkg::t_byte w_term;

    // remainder coefficient of this degree after one message byte
    assign w_term = i_prev_c ^ rsp_pkg::gf_mul(r_g, i_fb);

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_g <= {7'd0, i_seed};
            r_c <= '0;
        end else begin
            if (i_ctl.build) begin
                r_g <= i_prev_g ^ rsp_pkg::gf_mul(r_g, i_root);
            end
            if (i_ctl.shift) begin
                if (i_ctl.last) begin
                    r_c   <= '0;
                    r_par <= w_term;
                end else begin
                    r_c <= w_term;
                end
            end
        end
    end

    assign o_g   = r_g;
    assign o_c   = r_c;
    assign o_par = r_par;

endmodule

@@ rtl/core/reed_solomon_parity_encoder.sv @@
// top level of the reed-solomon parity encoder over gf(256), polynomial 0x11d
//
// i_in carries message bytes, last_byte closing each block; o_out carries the
// parity bytes of each block, highest degree first, parity_last on the final one.
// i_cfg_we / i_cfg_wdata write the parity count (saturated to 1..MAX_PARITY);
// a write between blocks rebuilds the generator, a write inside a block is dropped.
// one message byte is taken per cycle unless a rebuild or a waiting closing byte
// holds it off; each cell of the chain updates its remainder byte. the closing
// byte copies the remainder into the parity capture bytes, so the first parity
// item is offered the next cycle, the rest one per ready cycle, n per block.
// the next block's bytes keep flowing during that; only its closing byte waits
// until the previous block's last parity item is being taken.
// after reset or a count write the generator is rebuilt in the cells, one
// factor per cycle, and input is held off until it is built.
// a stalled receiver holds the current parity item steady.
module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [rsp_pkg::CFG_W-1:0] i_cfg_wdata,
    rsp_in_if.sink                   i_in,
    rsp_out_if.source                o_out
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);
    localparam int RESET_N = (rsp_pkg::RESET_PARITY > MAX_PARITY) ?
                             MAX_PARITY : rsp_pkg::RESET_PARITY;

    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_bcnt;
    logic [CW-1:0]      r_cnt;
    rsp_pkg::t_byte     r_root;
    logic               r_busy;

    rsp_pkg::t_byte     w_g   [MAX_PARITY];
    rsp_pkg::t_byte     w_c   [MAX_PARITY];
    rsp_pkg::t_byte     w_par [MAX_PARITY];

    rsp_pkg::t_cell_ctl w_ctl;
    rsp_pkg::t_byte     w_fb;
    logic [CW-1:0]      w_nm1;
    logic [CW-1:0]      w_cm1;
    logic [CW-1:0]      w_sat;
    logic               w_cfg_ok;
    logic               w_building;
    logic               w_free;
    logic               w_in_acc;
    logic               w_out_acc;

    assign w_cfg_ok   = i_cfg_we && !r_busy;
    assign w_building = (r_bcnt != '0);
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_free     = (r_cnt == '0) || ((r_cnt == CW'(1)) && o_out.ready);
    assign i_in.ready = !w_building && (!i_in.last_byte || w_free);
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_sat = CW'(1);
        end else if (int'(i_cfg_wdata) > MAX_PARITY) begin
            w_sat = CW'(MAX_PARITY);
        end else begin
            w_sat = CW'(i_cfg_wdata);
        end
    end

    // feedback taken from the top coefficient of the current degree
    assign w_nm1 = r_n - CW'(1);
    assign w_fb  = i_in.data_byte ^ w_c[w_nm1[IW-1:0]];

    always_comb begin
        w_ctl.init  = !i_rst_n || w_cfg_ok;
        w_ctl.build = w_building;
        w_ctl.shift = w_in_acc;
        w_ctl.last  = i_in.last_byte;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PARITY; k++) begin : g_cell
            if (k == 0) begin : g_head
                rsp_cell u_cell (
                    .i_clk    (i_clk),
                    .i_ctl    (w_ctl),
                    .i_seed   (1'b1),
                    .i_root   (r_root),
                    .i_fb     (w_fb),
                    .i_prev_g (8'd0),
                    .i_prev_c (8'd0),
                    .o_g      (w_g[k]),
                    .o_c      (w_c[k]),
                    .o_par    (w_par[k])
                );
            end else begin : g_body
                rsp_cell u_cell (
                    .i_clk    (i_clk),
                    .i_ctl    (w_ctl),
                    .i_seed   (1'b0),
                    .i_root   (r_root),
                    .i_fb     (w_fb),
                    .i_prev_g (w_g[k-1]),
                    .i_prev_c (w_c[k-1]),
                    .o_g      (w_g[k]),
                    .o_c      (w_c[k]),
                    .o_par    (w_par[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= CW'(RESET_N);
            r_bcnt <= CW'(RESET_N);
            r_root <= 8'd1;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (w_cfg_ok) begin
                r_n    <= w_sat;
                r_bcnt <= w_sat;
                r_root <= 8'd1;
            end else if (w_building) begin
                r_bcnt <= r_bcnt - CW'(1);
                r_root <= rsp_pkg::gf_xtime(r_root);
            end
            if (w_in_acc) begin
                r_busy <= !i_in.last_byte;
            end
            if (w_in_acc && i_in.last_byte) begin
                r_cnt <= r_n;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // parity bytes leave from the highest captured degree downwards
    assign w_cm1             = r_cnt - CW'(1);
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.parity_byte = w_par[w_cm1[IW-1:0]];
    assign o_out.parity_last = (r_cnt == CW'(1));

endmodule

@@ bench/reed_solomon_parity_encoder_tb.sv @@
// self-checking testbench for the reed-solomon parity encoder: directed and random blocks
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int NMAX        = rsp_pkg::MAX_PARITY_DEF;
    localparam int CFG_W       = rsp_pkg::CFG_W;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 40;
    localparam int LIMIT_TICKS = 600_000;
    localparam int RAND_PHASE  = 38;

    typedef rsp_pkg::t_byte t_byte;

    typedef struct {
        t_byte parity;
        logic  closing;
    } t_parity_item;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    rsp_in_if  in_ch ();
    rsp_out_if out_ch ();

    reed_solomon_parity_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // encoder copy kept by the bench
    int           parity_count;
    t_byte        rem_bytes [NMAX];
    t_byte        gen_coef [NMAX];
    t_parity_item pending_parity [$];

    int fail_count;
    bit in_calm;
    bit out_calm;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_byte gf_product(input t_byte a, input t_byte b);
        t_byte      acc;
        logic [8:0] p;
        acc = '0;
        p   = {1'b0, a};
        for (int i = 0; i < rsp_pkg::BYTE_W; i++) begin
            if (b[i]) begin
                acc = acc ^ p[7:0];
            end
            p = {p[7:0], 1'b0};
            if (p[8]) begin
                p = p ^ rsp_pkg::GF_POLY;
            end
        end
        return acc;
    endfunction

    // product of (x + a^i), i = 0 .. n-1, leading one dropped
    function automatic void rebuild_generator(input int n);
        t_byte poly [NMAX+1];
        t_byte root;
        root = 8'h01;
        foreach (poly[k]) poly[k] = '0;
        poly[0] = 8'h01;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j > 0; j--) begin
                poly[j] = poly[j-1] ^ gf_product(poly[j], root);
            end
            poly[0] = gf_product(poly[0], root);
            root    = gf_product(root, 8'h02);
        end
        for (int i = 0; i < NMAX; i++) begin
            gen_coef[i]  = (i < n) ? poly[i] : '0;
            rem_bytes[i] = '0;
        end
    endfunction

    function automatic void absorb_byte(input t_byte d, input logic closing);
        t_byte        fb;
        t_parity_item item;
        fb = d ^ rem_bytes[0];
        for (int j = 0; j + 1 < parity_count; j++) begin
            rem_bytes[j] = rem_bytes[j+1];
        end
        rem_bytes[parity_count-1] = '0;
        for (int j = 0; j < parity_count; j++) begin
            rem_bytes[j] = rem_bytes[j] ^ gf_product(gen_coef[parity_count-1-j], fb);
        end
        if (closing) begin
            for (int j = 0; j < parity_count; j++) begin
                item.parity  = rem_bytes[j];
                item.closing = (j + 1 == parity_count);
                pending_parity.push_back(item);
                rem_bytes[j] = '0;
            end
        end
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // caller sits just after a falling edge; valid stays high on return
    task automatic send_byte(input t_byte d, input logic closing);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = d;
        in_ch.last_byte = closing;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb_byte(d, closing);
        @(negedge i_clk);
    endtask

    task automatic send_block(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(t_byte'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_parity.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_parity_count(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        // zero and values above the maximum saturate
        parity_count = (v < 1) ? 1 : ((v > NMAX) ? NMAX : int'(v));
        rebuild_generator(parity_count);
    endtask

    // receiver: random stall before each parity item, with calm stretches
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        out_calm     = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                out_calm = !out_calm;
            end
            stall = out_calm ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_parity_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_parity.size() == 0) begin
                note_failure($sformatf("unexpected parity item: byte %02h last %0b",
                                       out_ch.parity_byte, out_ch.parity_last));
            end else begin
                want = pending_parity.pop_front();
                if (out_ch.parity_byte !== want.parity) begin
                    note_failure($sformatf("parity_byte: expected %02h, got %02h",
                                           want.parity, out_ch.parity_byte));
                end
                if (out_ch.parity_last !== want.closing) begin
                    note_failure($sformatf("parity_last: expected %0b, got %0b",
                                           want.closing, out_ch.parity_last));
                end
            end
        end
    end

    task automatic test_single_byte_blocks();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_short_message();
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_count_saturation();
        write_parity_count(5'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h00, 1'b1);
        write_parity_count(5'd31);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // sender holds off mid-block and between blocks until all parity is back
    task automatic test_drain_pause();
        write_parity_count(5'd13);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        wait_drained();
        send_byte(8'h96, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_drained();
        send_byte(8'h5A, 1'b1);
        wait_drained();
        send_block(3);
    endtask

    task automatic test_random_blocks();
        logic [CFG_W-1:0] counts [7];
        int               left;
        int               len;
        counts = '{5'd30, 5'd1, 5'd2, CFG_W'($urandom_range(3, 29)), 5'd7, 5'd16,
                   CFG_W'($urandom_range(0, 31))};
        foreach (counts[p]) begin
            write_parity_count(counts[p]);
            left = RAND_PHASE;
            while (left > 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    in_calm = !in_calm;
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 12);
                if (len > left) begin
                    len = left;
                end
                send_block(len);
                left -= len;
            end
        end
        in_calm = 1'b0;
    endtask

    initial begin
        fail_count      = 0;
        in_calm         = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        parity_count    = rsp_pkg::RESET_PARITY;
        rebuild_generator(parity_count);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_byte_blocks();
        test_short_message();
        test_count_saturation();
        test_drain_pause();
        test_random_blocks();

        wait_drained();
        repeat (TAIL) @(negedge i_clk);
        if (fail_count == 0 && pending_parity.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TICKS * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ reed_solomon_parity_encoder.f @@
rtl/core/rsp_pkg.sv
rtl/core/rsp_if.sv
rtl/core/rsp_cell.sv
rtl/core/reed_solomon_parity_encoder.sv
bench/reed_solomon_parity_encoder_tb.sv
